// File: hw/rtl/upc_pkg.sv
`default_nettype none

package upc_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // result slots per input byte
    localparam int unsigned MaxResults = 3;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_phase_t;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    function automatic logic is_unreserved(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h61) && (c <= 8'h7A)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
        return r;
    endfunction

    // hex digit value, no validity check
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] lower;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            return 8'(c - 8'h30);
        end
        lower = ((c >= 8'h41) && (c <= 8'h5A)) ? 8'(c + 8'h20) : c;
        return 8'(lower - 8'h57);
    endfunction

    function automatic logic [7:0] plain_decode(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/upc_if.sv
`default_nettype none

interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input string_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/url_percent_codec_top.sv
`default_nettype none
// Channel   | Dir | Payload                                    | Handshake
// ----------+-----+--------------------------------------------+-----------
// in_ch     | in  | in_byte[7:0], in_last                      | valid/ready
// out_ch    | out | out_byte[7:0], has_byte, run_last, string_end | valid/ready
// cfg       | in  | cfg_wdata (mode)                           | cfg_we only
//
// Each accepted byte is translated in the cycle it is taken and lands in a
// three-slot result buffer; its first result is offered the next cycle. The
// buffer drains one result per cycle while the output is ready: one result
// for a passed or decoded byte or an end-only marker, three for an encoded
// escape. A byte that only advances an escape leaves no result. The next
// byte is taken in the cycle the final result of the previous one leaves.
// Reset (rst_n low, asynchronous) empties the buffer and clears mode and
// escape state. A stalled output holds the buffer and input ready low.

module url_percent_codec_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    upc_in_if.sink     in_ch,
    upc_out_if.source  out_ch
);
    import upc_pkg::*;

    // configuration and escape tracking
    logic       mode_reg;
    esc_phase_t esc_reg,  esc_next;
    logic [7:0] held_reg, held_next;

    // result buffer: up to three bytes from one transaction
    logic       buf_valid_reg, buf_valid_next;
    logic [7:0] buf_byte_reg [MaxResults];
    logic [1:0] buf_cnt_reg;
    logic [1:0] idx_reg,      idx_next;
    logic       buf_has_reg;
    logic       buf_end_reg;

    // translation of the byte on the input port
    logic [1:0] gen_n;
    logic [7:0] gen_b [MaxResults];
    logic       gen_has;
    logic [7:0] hi_val;
    logic [7:0] dec_val;

    logic in_fire;
    logic out_fire;
    logic out_final;

    assign out_final = (idx_reg == 2'(buf_cnt_reg - 2'd1));
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign in_fire   = in_ch.valid && in_ch.ready;

    // take a new byte once the buffer is empty or emptying this cycle
    assign in_ch.ready = !buf_valid_reg || (out_ch.ready && out_final);

    assign out_ch.valid      = buf_valid_reg;
    assign out_ch.out_byte   = buf_byte_reg[idx_reg];
    assign out_ch.has_byte   = buf_has_reg;
    assign out_ch.run_last   = out_final;
    assign out_ch.string_end = out_final && buf_end_reg;

    // %hh: high digit from the held byte, low digit from the current one
    assign hi_val  = digit_value(held_reg);
    assign dec_val = {hi_val[3:0], 4'h0} | digit_value(in_ch.in_byte);

    always_comb
    begin
        esc_next = esc_reg;
        held_next = held_reg;
        gen_n = 2'd0;
        gen_has = 1'b1;
        for (int i = 0; i < MaxResults; i++)
        begin
            gen_b[i] = 8'h00;
        end

        if (mode_reg == MODE_ENCODE)
        begin
            if (is_unreserved(in_ch.in_byte))
            begin
                gen_n = 2'd1;
                gen_b[0] = in_ch.in_byte;
            end
            else if (in_ch.in_byte == CH_SPACE)
            begin
                gen_n = 2'd1;
                gen_b[0] = CH_PLUS;
            end
            else
            begin
                gen_n = 2'd3;
                gen_b[0] = CH_PCT;
                gen_b[1] = HEX_CHARS[in_ch.in_byte[7:4]];
                gen_b[2] = HEX_CHARS[in_ch.in_byte[3:0]];
            end
        end
        else
        begin
            unique case (esc_reg)
                ESC_PCT:
                begin
                    if (in_ch.in_last)
                    begin
                        // escape cut short: this byte decodes as ordinary, unless it is another '%'
                        if (in_ch.in_byte != CH_PCT)
                        begin
                            gen_n = 2'd1;
                            gen_b[0] = plain_decode(in_ch.in_byte);
                        end
                    end
                    else
                    begin
                        held_next = in_ch.in_byte;
                        esc_next = ESC_DIGIT;
                    end
                end
                ESC_DIGIT:
                begin
                    gen_n = 2'd1;
                    gen_b[0] = dec_val;
                    esc_next = ESC_IDLE;
                    held_next = 8'h00;
                end
                default:
                begin
                    esc_next = ESC_IDLE;
                    if (in_ch.in_byte == CH_PCT)
                    begin
                        if (!in_ch.in_last)
                        begin
                            esc_next = ESC_PCT;
                        end
                    end
                    else
                    begin
                        gen_n = 2'd1;
                        gen_b[0] = plain_decode(in_ch.in_byte);
                    end
                end
            endcase
        end

        if (in_ch.in_last)
        begin
            esc_next = ESC_IDLE;
            held_next = 8'h00;
            if (gen_n == 2'd0)
            begin
                // end-only marker
                gen_n = 2'd1;
                gen_has = 1'b0;
            end
        end
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next = idx_reg;
        if (in_fire)
        begin
            buf_valid_next = (gen_n != 2'd0);
            idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            if (out_final)
            begin
                buf_valid_next = 1'b0;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = 2'(idx_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            esc_reg <= ESC_IDLE;
            held_reg <= 8'h00;
            buf_valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg <= idx_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
                esc_reg <= ESC_IDLE;
                held_reg <= 8'h00;
            end
            else if (in_fire)
            begin
                esc_reg <= esc_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MaxResults; i++)
            begin
                buf_byte_reg[i] <= gen_b[i];
            end
            buf_cnt_reg <= gen_n;
            buf_has_reg <= gen_has;
            buf_end_reg <= in_ch.in_last;
        end
    end

    // an end-only marker always closes both the transaction and the string
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.has_byte) |->
            (out_ch.run_last && out_ch.string_end && (out_ch.out_byte == 8'h00)))
        else $error("end-only marker malformed");

    // escape state only ever moves in decode mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (esc_reg != ESC_IDLE) |-> (mode_reg == MODE_DECODE))
        else $error("escape pending in encode mode");

    // the read slot stays within the filled part of the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> ((idx_reg < buf_cnt_reg) && (buf_cnt_reg != 2'd0)))
        else $error("result index beyond buffer fill");

    // a taken result that is not the last of its transaction leaves another
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !out_ch.run_last) |=> out_ch.valid)
        else $error("results of a transaction lost");

endmodule

`default_nettype wire

// File: tb/url_codec_checker.sv
`default_nettype none

module url_codec_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        has_byte,
    input  logic        run_last,
    input  logic        string_end,
    output int unsigned fail_count,
    output int unsigned pending
);
    import upc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       run_end;
        logic       str_end;
    } codec_result_t;

    // shadow of the block's mode and escape state
    logic          mode;
    esc_phase_t    phase;
    logic [7:0]    held;
    codec_result_t expected_q[$];

    function automatic logic passes_unescaped(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_DASH) || (c == CH_UNDER) ||
               (c == CH_DOT) || (c == CH_TILDE);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
    endfunction

    // no check that c really is a hex digit
    function automatic logic [7:0] nibble_value(input logic [7:0] c);
        logic [7:0] lc;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            return c - 8'h30;
        end
        lc = ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
        return lc - 8'h57;
    endfunction

    function automatic logic [7:0] unplus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic codec_result_t byte_result(input logic [7:0] b);
        return '{b, 1'b1, 1'b0, 1'b0};
    endfunction

    task automatic predict(input logic [7:0] c, input logic last);
        codec_result_t res [MaxResults];
        int            n;
        logic [7:0]    hi;
        n = 0;
        if (mode == MODE_ENCODE) begin
            if (passes_unescaped(c)) begin
                res[0] = byte_result(c);
                n = 1;
            end else if (c == CH_SPACE) begin
                res[0] = byte_result(CH_PLUS);
                n = 1;
            end else begin
                res[0] = byte_result(CH_PCT);
                res[1] = byte_result(hex_char(c[7:4]));
                res[2] = byte_result(hex_char(c[3:0]));
                n = 3;
            end
        end else begin
            case (phase)
                ESC_PCT: begin
                    if (last) begin
                        // escape cut short: the byte after '%' is taken as plain, unless it is '%'
                        if (c != CH_PCT) begin
                            res[0] = byte_result(unplus(c));
                            n = 1;
                        end
                    end else begin
                        held  = c;
                        phase = ESC_DIGIT;
                    end
                end
                ESC_DIGIT: begin
                    hi     = nibble_value(held);
                    res[0] = byte_result((hi << 4) | nibble_value(c));
                    n      = 1;
                    phase  = ESC_IDLE;
                    held   = 8'h00;
                end
                default: begin
                    phase = ESC_IDLE;
                    if (c == CH_PCT) begin
                        if (!last) phase = ESC_PCT;
                    end else begin
                        res[0] = byte_result(unplus(c));
                        n = 1;
                    end
                end
            endcase
        end
        if (last) begin
            phase = ESC_IDLE;
            held  = 8'h00;
            if (n == 0) begin
                res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
                n = 1;
            end
            res[n-1].str_end = 1'b1;
        end
        if (n > 0) res[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
    endtask

    task automatic report(input string what, input codec_result_t exp,
                          input codec_result_t act);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch (%s): expected byte %h has %b run %b end %b",
                     $realtime, what, exp.data, exp.has_data, exp.run_end, exp.str_end);
            $display("    got byte %h has %b run %b end %b",
                     act.data, act.has_data, act.run_end, act.str_end);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        codec_result_t act;
        codec_result_t exp;
        if (!rst_n) begin
            mode       = MODE_ENCODE;
            phase      = ESC_IDLE;
            held       = 8'h00;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                mode  = cfg_wdata;
                phase = ESC_IDLE;
                held  = 8'h00;
            end
            if (in_valid && in_ready) predict(in_byte, in_last);
            if (out_valid && out_ready) begin
                act = '{out_byte, has_byte, run_last, string_end};
                if (expected_q.size() == 0) begin
                    report("unexpected", '0, act);
                end else begin
                    exp = expected_q.pop_front();
                    if (act.data !== exp.data || act.has_data !== exp.has_data ||
                        act.run_end !== exp.run_end || act.str_end !== exp.str_end)
                        report("field", exp, act);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

// Stimulus and verdict for the URL percent codec. The checker beside the
// block predicts every result and counts mismatches; this module only makes
// traffic, writes the mode register between phases and decides the outcome.
module tb;
    import upc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles (no transaction on either channel) before giving up.
    localparam int unsigned QuietLimit = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    int unsigned fail_count;
    int unsigned pending;

    upc_in_if  in_ch ();
    upc_out_if out_ch ();

    // Idling odds, in percent, for each side; changed per phase.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned quiet_cycles;
    logic        cur_mode;
    logic [7:0]  text_q[$];
    string       unreserved_chars = "azAZ09-_.~mQ";

    url_percent_codec_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    url_codec_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_byte    (in_ch.in_byte),
        .in_last    (in_ch.in_last),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_byte   (out_ch.out_byte),
        .has_byte   (out_ch.has_byte),
        .run_last   (out_ch.run_last),
        .string_end (out_ch.string_end),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure: a fresh random draw against recv_idle_pct every cycle, on the falling edge.
    always @(negedge clk)
    begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: counts cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one byte. Called at a falling edge; returns at the falling edge
    // after the transaction, with valid still high so back-to-back bytes
    // need no gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.in_last = last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    task automatic send_text_q();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Let the block drain. A byte that only advances an escape leaves no
    // result behind, so wait on past the last expected result.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_mode  = m;
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic logic [7:0] pick_unreserved();
        return unreserved_chars[$urandom_range(unreserved_chars.len() - 1)];
    endfunction

    // Hex digit in either case, so both paths of the digit decoder get used.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Encode strings: mostly raw bytes from 8'h01 to 8'hFF, with a good
    // share of pass-through characters and spaces.
    task automatic build_encode_string();
        int unsigned r;
        text_q.delete();
        repeat ($urandom_range(6, 1))
        begin
            r = $urandom_range(99);
            if (r < 30)      text_q.push_back(pick_unreserved());
            else if (r < 40) text_q.push_back(CH_SPACE);
            else             text_q.push_back(any_byte());
        end
    endtask

    // Decode strings: mostly well-formed escapes, '+' and plain characters,
    // plus some noise bytes and now and then a truncated escape at the end.
    task automatic build_decode_string();
        int unsigned r;
        text_q.delete();
        repeat ($urandom_range(5, 1))
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                text_q.push_back(CH_PCT);
                text_q.push_back(hex_digit(4'($urandom_range(15))));
                text_q.push_back(hex_digit(4'($urandom_range(15))));
            end
            else if (r < 60) text_q.push_back(CH_PLUS);
            else if (r < 88) text_q.push_back(pick_unreserved());
            else             text_q.push_back(any_byte());
        end
        r = $urandom_range(99);
        if (r < 6)
            text_q.push_back(CH_PCT);
        else if (r < 12)
        begin
            text_q.push_back(CH_PCT);
            text_q.push_back(any_byte());
        end
    endtask

    task automatic random_strings(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if (cur_mode == MODE_DECODE) build_decode_string();
            else                         build_encode_string();
            send_text_q();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = MODE_ENCODE;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.in_last  = 1'b0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 27;
        recv_idle_pct  = 48;
        items_sent     = 0;
        quiet_cycles   = 0;
        cur_mode       = MODE_ENCODE;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed encode: range extremes, top-bit bytes, pass-through,
        // space and characters that need escaping.
        set_mode(MODE_ENCODE);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("a~ %", 1'b1);

        // Directed decode: '+', escapes in both cases, then every way an
        // escape can be cut short by the end of the string, non-hex digits,
        // and plain extremes.
        set_mode(MODE_DECODE);
        send_text("+%4a%F0", 1'b1);
        send_text("%", 1'b1);          // lone '%' -> end-only marker
        send_text("%4", 1'b1);         // '%' dropped, '4' passes
        send_text("%+", 1'b1);         // '%' dropped, '+' gives space
        send_text("%%", 1'b1);         // both dropped -> end-only marker
        send_text("%Gz", 1'b1);        // digits not checked
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Random traffic under three idling regimes, both modes in each.
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0: begin send_idle_pct = 27; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            set_mode((p == 1) ? MODE_ENCODE : MODE_DECODE);
            random_strings(56);
            set_mode((p == 1) ? MODE_DECODE : MODE_ENCODE);
            random_strings(56);
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
